FILE: rtl/core/kced_pkg.sv
// ----------------------------------------------------------------------------
// kced_pkg
// Shared types, constants and helpers for the key change event detector.
// ----------------------------------------------------------------------------
package kced_pkg;

   localparam int KEY_COUNT       = 256;
   localparam int SLOTS_PER_GROUP = 8;

   localparam int NUM_GROUPS = 8;
   localparam int NUM_CHUNKS = 4;
   localparam int CHUNK_W    = 64;
   localparam int CODE_W     = 8;
   localparam int CSR_IDX_W  = $clog2(NUM_GROUPS);

   // modifier state bit positions
   localparam int MOD_SHIFT   = 0;
   localparam int MOD_CONTROL = 2;
   localparam int MOD_ALT     = 3;

   typedef struct packed {
      logic [1:0]         chunk_index;
      logic [CHUNK_W-1:0] chunk_keys;
      logic               last_chunk;
   } req_type;

   typedef struct packed {
      logic              pressed;
      logic [CODE_W-1:0] raw_keycode;
      logic [CODE_W-1:0] mapped_keycode;
      logic [7:0]        modifier_bits;
      logic              shift_held;
      logic              control_held;
      logic              alt_held;
   } rsp_type;

   // keys at or above KEY_COUNT are masked off
   function automatic logic [CHUNK_W-1:0] chunk_mask(input logic [1:0] ci);
      int base;
      int span;
      base = int'(ci) * CHUNK_W;
      span = KEY_COUNT - base;
      if (base >= KEY_COUNT) begin
         return '0;
      end else if (span >= CHUNK_W) begin
         return '1;
      end else begin
         return (CHUNK_W'(1) << span) - CHUNK_W'(1);
      end
   endfunction

   // index of lowest set bit: isolate it, then encode the one-hot
   function automatic logic [5:0] lowest_index(input logic [63:0] v);
      logic [63:0] one;
      logic [5:0]  idx;
      one = v & (~v + 64'd1);
      idx = '0;
      for (int b = 0; b < 6; b++) begin
         for (int i = 0; i < 64; i++) begin
            if (((i >> b) & 1) == 1) begin
               idx[b] = idx[b] | one[i];
            end
         end
      end
      return idx;
   endfunction

   // index of highest set bit
   function automatic logic [5:0] highest_index(input logic [63:0] v);
      logic [63:0] rev;
      for (int i = 0; i < 64; i++) begin
         rev[i] = v[63-i];
      end
      return ~lowest_index(rev);
   endfunction

   // fixed keycode remap
   function automatic logic [CODE_W-1:0] remap_code(input logic [CODE_W-1:0] c);
      logic [CODE_W-1:0] r;
      if (c >= 8'd9 && c <= 8'd96) begin
         r = c - 8'd8;
      end else if (c >= 8'd133 && c <= 8'd137) begin
         r = c + 8'd86;
      end else begin
         unique case (c)
            8'd105:  r = 8'd157;
            8'd108:  r = 8'd184;
            8'd127:  r = 8'd197;
            8'd110:  r = 8'd199;
            8'd111:  r = 8'd200;
            8'd112:  r = 8'd201;
            8'd113:  r = 8'd203;
            8'd114:  r = 8'd205;
            8'd115:  r = 8'd207;
            8'd116:  r = 8'd208;
            8'd117:  r = 8'd209;
            8'd118:  r = 8'd210;
            8'd119:  r = 8'd211;
            default: r = c;
         endcase
      end
      return r;
   endfunction

endpackage

FILE: rtl/core/key_change_event_detector.sv
// ----------------------------------------------------------------------------
// key_change_event_detector
// Finds the first changed key per snapshot and emits one press/release event.
// ----------------------------------------------------------------------------
// Takes one chunk beat per clock cycle, back to back, while req_stall is
// low, and passes each event through the keymap read, change search and
// keymap write-back, modifier update and output register stages. The
// rate is set by the single keymap memory read-modify-write per beat; a
// chunk that follows a write to the same chunk picks up the new word by
// forwarding. Stall on the result side backs up through the three stages
// and reaches req_stall only once all of them hold data. The stored keymap
// reads as all zero after reset with no clearing pass; the group code
// registers may be written only while the block is idle.
module key_change_event_detector
   import kced_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  req_type              req_data,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output rsp_type              rsp_data,
   input  logic                 csr_wr_en,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [63:0]          csr_wdata
);

   // group code registers
   logic [63:0] group_codes_ff [NUM_GROUPS];

   // keymap memory and per-entry valid bits (invalid entry reads as zero)
   logic [CHUNK_W-1:0]    keymap_mem [NUM_CHUNKS];
   logic [NUM_CHUNKS-1:0] key_valid_ff;

   // stage 1: chunk plus registered memory read
   logic               s1_valid_ff;
   req_type            s1_req_ff;
   logic [CHUNK_W-1:0] rd_data_ff;
   logic               rd_valid_ff;
   logic               fwd_hit_ff;
   logic [CHUNK_W-1:0] fwd_data_ff;
   logic               event_taken_ff;

   // stage 2: pending event
   logic              s2_valid_ff;
   logic              s2_down_ff;
   logic [CODE_W-1:0] s2_code_ff;

   // modifier tracking
   logic [7:0] slot_bits_ff [NUM_GROUPS];
   logic [7:0] modifier_state_ff;

   // output register
   logic    rsp_valid_ff;
   rsp_type rsp_data_ff;

   // flow control
   logic adv_out;
   logic s2_free;
   logic s1_free;
   logic s1_fire;
   logic accept;

   // stage 1 logic
   logic [CHUNK_W-1:0] cur_word;
   logic [CHUNK_W-1:0] diff;
   logic [5:0]         pos;
   logic               has_event;
   logic [CHUNK_W-1:0] wr_data;
   logic               down;

   // stage 2 logic
   logic [63:0]           match;
   logic                  hit;
   logic [5:0]            hit_idx;
   logic [CSR_IDX_W-1:0]  hit_g;
   logic [2:0]            hit_s;
   logic [7:0]            slot_bits_in;
   logic [7:0]            modifier_state_in;
   logic                  out_load;
   rsp_type               rsp_data_in;

   // --- flow control: each stage moves when the one after has room ---------
   assign adv_out   = !rsp_valid_ff || !rsp_stall;
   assign s2_free   = !s2_valid_ff || adv_out;
   assign s1_free   = !s1_valid_ff || s2_free;
   assign s1_fire   = s1_valid_ff && s2_free;
   assign accept    = req_valid && s1_free;
   assign req_stall = !s1_free;
   assign out_load  = s2_valid_ff && adv_out;

   // --- configuration --------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int g = 0; g < NUM_GROUPS; g++) begin
            group_codes_ff[g] <= '0;
         end
      end else if (csr_wr_en) begin
         group_codes_ff[csr_index] <= csr_wdata;
      end
   end

   // --- stage 1: change search ---------------------------------------------
   // a write from the beat ahead wins over the stale memory read
   always_comb begin
      priority if (fwd_hit_ff) begin
         cur_word = fwd_data_ff;
      end else if (rd_valid_ff) begin
         cur_word = rd_data_ff;
      end else begin
         cur_word = '0;
      end
      diff      = (cur_word ^ s1_req_ff.chunk_keys) & chunk_mask(s1_req_ff.chunk_index);
      pos       = lowest_index(diff);
      has_event = s1_fire && !event_taken_ff && (diff != '0);
      wr_data   = cur_word ^ (CHUNK_W'(1) << pos);
      down      = s1_req_ff.chunk_keys[pos];
   end

   // keymap memory: one write, one registered read
   always_ff @(posedge clock) begin
      if (has_event) begin
         keymap_mem[s1_req_ff.chunk_index] <= wr_data;
      end
      if (accept) begin
         rd_data_ff  <= keymap_mem[req_data.chunk_index];
         s1_req_ff   <= req_data;
         fwd_data_ff <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         key_valid_ff   <= '0;
         s1_valid_ff    <= 1'b0;
         rd_valid_ff    <= 1'b0;
         fwd_hit_ff     <= 1'b0;
         event_taken_ff <= 1'b0;
      end else begin
         if (has_event) begin
            key_valid_ff[s1_req_ff.chunk_index] <= 1'b1;
         end
         if (s1_free) begin
            s1_valid_ff <= req_valid;
         end
         if (accept) begin
            rd_valid_ff <= key_valid_ff[req_data.chunk_index];
            fwd_hit_ff  <= has_event && (s1_req_ff.chunk_index == req_data.chunk_index);
         end
         // end of snapshot re-arms the search
         if (s1_fire) begin
            if (s1_req_ff.last_chunk) begin
               event_taken_ff <= 1'b0;
            end else if (has_event) begin
               event_taken_ff <= 1'b1;
            end
         end
      end
   end

   // --- stage 2 register -----------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else if (s2_free) begin
         s2_valid_ff <= has_event;
      end
   end

   always_ff @(posedge clock) begin
      if (has_event) begin
         s2_down_ff <= down;
         s2_code_ff <= {s1_req_ff.chunk_index, pos};
      end
   end

   // --- stage 2: modifier group lookup ---------------------------------------
   // highest group, then highest slot wins; code zero marks an empty slot
   always_comb begin
      for (int g = 0; g < NUM_GROUPS; g++) begin
         for (int s = 0; s < 8; s++) begin
            match[g*8+s] = (s < SLOTS_PER_GROUP) && (s2_code_ff != '0) &&
                           (group_codes_ff[g][8*s +: 8] == s2_code_ff);
         end
      end
      hit     = (match != '0);
      hit_idx = highest_index(match);
      hit_g   = hit_idx[5:3];
      hit_s   = hit_idx[2:0];
      if (s2_down_ff) begin
         slot_bits_in = slot_bits_ff[hit_g] | (8'd1 << hit_s);
      end else begin
         slot_bits_in = slot_bits_ff[hit_g] & ~(8'd1 << hit_s);
      end
      modifier_state_in = modifier_state_ff;
      if (hit) begin
         modifier_state_in[hit_g] = (slot_bits_in != '0);
      end
      rsp_data_in.pressed        = s2_down_ff;
      rsp_data_in.raw_keycode    = s2_code_ff;
      rsp_data_in.mapped_keycode = remap_code(s2_code_ff);
      rsp_data_in.modifier_bits  = modifier_state_in;
      rsp_data_in.shift_held     = modifier_state_in[MOD_SHIFT];
      rsp_data_in.control_held   = modifier_state_in[MOD_CONTROL];
      rsp_data_in.alt_held       = modifier_state_in[MOD_ALT];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int g = 0; g < NUM_GROUPS; g++) begin
            slot_bits_ff[g] <= '0;
         end
         modifier_state_ff <= '0;
      end else if (out_load && hit) begin
         slot_bits_ff[hit_g] <= slot_bits_in;
         modifier_state_ff   <= modifier_state_in;
      end
   end

   // --- output register ------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (adv_out) begin
         rsp_valid_ff <= s2_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (out_load) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

FILE: rtl/core/kced_checker.sv
// ----------------------------------------------------------------------------
// kced_checker
// Port-level checks for the key change event detector, bound to the top.
// ----------------------------------------------------------------------------
module kced_checker
   import kced_pkg::*;
(
   input logic    clock,
   input logic    reset,
   input logic    rsp_valid,
   input logic    rsp_stall,
   input rsp_type rsp_data
);

   // a stalled result beat holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("result beat changed under stall");

   // no result straight out of reset
   a_rsp_reset: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result beat valid after reset");

   // named flags agree with the modifier vector
   a_flags: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_data.shift_held == rsp_data.modifier_bits[MOD_SHIFT] &&
                    rsp_data.control_held == rsp_data.modifier_bits[MOD_CONTROL] &&
                    rsp_data.alt_held == rsp_data.modifier_bits[MOD_ALT])
      else $error("modifier flags disagree with modifier bits");

   // a result beat for key zero leaves the modifier state as it was
   a_mod_steady: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_stall ##1 rsp_valid && $past(rsp_valid) && $past(!rsp_stall) &&
      rsp_data.raw_keycode == 8'd0 |-> rsp_data.modifier_bits == $past(rsp_data.modifier_bits))
      else $error("key zero changed the modifier state");

endmodule

bind key_change_event_detector kced_checker u_kced_checker (.*);

FILE: tb/testbench.sv
// ----------------------------------------------------------------------------
// Key change event detector testbench
// Sends key snapshot chunks, predicts each press or release event and checks
// every event beat against the prediction, under random idling on both sides.
// ----------------------------------------------------------------------------
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   import kced_pkg::*;

   // group code register indexes
   localparam int REG_SHIFT_GROUP     = 0;
   localparam int REG_LOCK_GROUP      = 1;
   localparam int REG_CONTROL_GROUP   = 2;
   localparam int REG_MOD_ONE_GROUP   = 3;
   localparam int REG_MOD_TWO_GROUP   = 4;
   localparam int REG_MOD_THREE_GROUP = 5;
   localparam int REG_MOD_FOUR_GROUP  = 6;
   localparam int REG_MOD_FIVE_GROUP  = 7;

   localparam int WATCHDOG_LIMIT = 2000;  // cycles with no beat on either side
   localparam int DRAIN_CYCLES   = 10;    // pipeline is three deep
   localparam int HOLD_CYCLES    = 300;   // long result-side hold-off
   localparam int IDLE_PERCENT   = 29;

   // -------------------------------------------------------------------------
   // Event tracker: keeps its own key map, slot bits and modifier state, and
   // queues the event each accepted chunk should produce.
   // -------------------------------------------------------------------------
   class key_event_tracker;
      bit [63:0] group_codes [NUM_GROUPS];
      bit [63:0] keymap      [NUM_CHUNKS];
      bit [7:0]  slot_bits   [NUM_GROUPS];
      bit [7:0]  mod_state;
      bit        event_seen;   // event already given in this snapshot
      rsp_type   due_events [$];
      int        mismatches;

      function new();
         foreach (group_codes[g]) group_codes[g] = '0;
         foreach (keymap[c]) keymap[c] = '0;
         foreach (slot_bits[g]) slot_bits[g] = '0;
         mod_state  = '0;
         event_seen = 1'b0;
         mismatches = 0;
      endfunction

      function void set_group(int g, bit [63:0] codes);
         group_codes[g] = codes;
      endfunction

      function bit [7:0] remapped_code(bit [7:0] c);
         if (c >= 8'd9 && c <= 8'd96) return c - 8'd8;
         if (c >= 8'd133 && c <= 8'd137) return c + 8'd86;
         case (c)
            8'd105: return 8'd157;
            8'd108: return 8'd184;
            8'd110: return 8'd199;
            8'd111: return 8'd200;
            8'd112: return 8'd201;
            8'd113: return 8'd203;
            8'd114: return 8'd205;
            8'd115: return 8'd207;
            8'd116: return 8'd208;
            8'd117: return 8'd209;
            8'd118: return 8'd210;
            8'd119: return 8'd211;
            8'd127: return 8'd197;
            default: return c;
         endcase
      endfunction

      function void take_chunk(req_type beat);
         bit [63:0] live;
         bit [63:0] diff;
         int        base;
         int        pos;
         int        hit_g;
         int        hit_s;
         bit [7:0]  code;
         bit        down;
         rsp_type   ev;
         base = int'(beat.chunk_index) * CHUNK_W;
         if (base >= KEY_COUNT) live = '0;
         else if (KEY_COUNT - base >= CHUNK_W) live = '1;
         else live = (64'd1 << (KEY_COUNT - base)) - 64'd1;
         if (!event_seen) begin
            diff = (keymap[beat.chunk_index] ^ beat.chunk_keys) & live;
            if (diff != '0) begin
               pos = 0;
               for (int i = 63; i >= 0; i--) if (diff[i]) pos = i;
               keymap[beat.chunk_index][pos] = ~keymap[beat.chunk_index][pos];
               down  = beat.chunk_keys[pos];
               code  = 8'(base + pos);
               hit_g = -1;
               hit_s = 0;
               // later group / slot overrides earlier on a repeated code
               for (int g = 0; g < NUM_GROUPS; g++)
                  for (int s = 0; s < SLOTS_PER_GROUP && s < 8; s++)
                     if (code != 8'd0 && group_codes[g][8*s +: 8] == code) begin
                        hit_g = g;
                        hit_s = s;
                     end
               if (hit_g >= 0) begin
                  slot_bits[hit_g][hit_s] = down;
                  mod_state[hit_g] = (slot_bits[hit_g] != 8'd0);
               end
               ev.pressed        = down;
               ev.raw_keycode    = code;
               ev.mapped_keycode = remapped_code(code);
               ev.modifier_bits  = mod_state;
               ev.shift_held     = mod_state[MOD_SHIFT];
               ev.control_held   = mod_state[MOD_CONTROL];
               ev.alt_held       = mod_state[MOD_ALT];
               due_events.push_back(ev);
               event_seen = 1'b1;
            end
         end
         if (beat.last_chunk) event_seen = 1'b0;
      endfunction

      function void check_event(rsp_type got);
         rsp_type want;
         if (due_events.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("%0t: unexpected event beat: pressed=%0d raw=%0d", $realtime,
                        got.pressed, got.raw_keycode);
            return;
         end
         want = due_events.pop_front();
         if (got.pressed !== want.pressed || got.raw_keycode !== want.raw_keycode ||
             got.mapped_keycode !== want.mapped_keycode ||
             got.modifier_bits !== want.modifier_bits ||
             got.shift_held !== want.shift_held || got.control_held !== want.control_held ||
             got.alt_held !== want.alt_held) begin
            mismatches++;
            if (mismatches <= 10) begin
               $display("%0t: event mismatch", $realtime);
               $display("   exp pressed=%0d raw=%0d mapped=%0d mods=%02h sh=%0d ct=%0d al=%0d",
                        want.pressed, want.raw_keycode, want.mapped_keycode,
                        want.modifier_bits, want.shift_held, want.control_held,
                        want.alt_held);
               $display("   got pressed=%0d raw=%0d mapped=%0d mods=%02h sh=%0d ct=%0d al=%0d",
                        got.pressed, got.raw_keycode, got.mapped_keycode,
                        got.modifier_bits, got.shift_held, got.control_held,
                        got.alt_held);
            end
         end
      endfunction
   endclass

   // -------------------------------------------------------------------------
   // DUT hookup
   // -------------------------------------------------------------------------
   logic                 clock     = 1'b0;
   logic                 reset     = 1'b1;
   logic                 req_valid = 1'b0;
   logic                 req_stall;
   req_type              req_data  = '0;
   logic                 rsp_valid;
   logic                 rsp_stall = 1'b0;
   rsp_type              rsp_data;
   logic                 csr_wr_en = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [63:0]          csr_wdata = '0;

   key_event_tracker tracker = new();

   bit          calm         = 1'b0;   // no idling on either side while set
   bit          hold_request = 1'b0;   // asks the receiver for a long hold-off
   bit [63:0]   group_plan [NUM_GROUPS];
   bit [63:0]   target     [NUM_CHUNKS]; // key state the scan source reports
   int          quiet_cycles = 0;

   key_change_event_detector dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   function automatic bit idle_roll();
      return !calm && ($urandom_range(99) < IDLE_PERCENT);
   endfunction

   // -------------------------------------------------------------------------
   // Result side: check each event beat, then pick next cycle's stall. The
   // hold-off is counted here so the sender keeps pushing meanwhile.
   // -------------------------------------------------------------------------
   initial begin
      int hold_left;
      hold_left = 0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_valid && !rsp_stall) tracker.check_event(rsp_data);
         if (hold_left > 0) begin
            hold_left--;
            rsp_stall <= 1'b1;
         end else if (hold_request) begin
            hold_request = 1'b0;
            hold_left    = HOLD_CYCLES;
            rsp_stall   <= 1'b1;
         end else begin
            rsp_stall <= idle_roll();
         end
      end
   end

   // Watchdog: too long without a beat on either channel ends the run.
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("%0t: no beat for %0d cycles", $realtime, WATCHDOG_LIMIT);
         $display("Test completed with failures");
         $finish;
      end
   end

   // -------------------------------------------------------------------------
   // Chunk side
   // -------------------------------------------------------------------------
   // Returns at the edge that takes the beat; valid stays up for a follow-on
   // beat and only drops when a gap or the end of a phase comes.
   task automatic send_chunk(input bit [1:0] ci, input bit [63:0] keys, input bit last);
      req_type beat;
      beat.chunk_index = ci;
      beat.chunk_keys  = keys;
      beat.last_chunk  = last;
      while (idle_roll()) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= beat;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      tracker.take_chunk(beat);
   endtask

   // Group registers only change with the block idle.
   task automatic write_groups();
      for (int g = 0; g < NUM_GROUPS; g++) begin
         csr_wr_en <= 1'b1;
         csr_index <= CSR_IDX_W'(g);
         csr_wdata <= group_plan[g];
         @(posedge clock);
         tracker.set_group(g, group_plan[g]);
      end
      csr_wr_en <= 1'b0;
   endtask

   // Drain: every event in, then an idle wait for beats that give none.
   task automatic settle();
      req_valid <= 1'b0;
      while (tracker.due_events.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // Mostly keys that sit in a group, so modifier state keeps moving.
   task automatic toggle_some_keys();
      int        n;
      int        g;
      int        s;
      bit [7:0]  code;
      n = $urandom_range(0, 3);
      for (int i = 0; i < n; i++) begin
         g    = $urandom_range(NUM_GROUPS - 1);
         s    = $urandom_range(SLOTS_PER_GROUP - 1);
         code = tracker.group_codes[g][8*s +: 8];
         if ($urandom_range(99) < 40 || code == 8'd0) code = 8'($urandom_range(255));
         target[code[7:6]][code[5:0]] = ~target[code[7:6]][code[5:0]];
      end
      if ($urandom_range(99) < 4) target[$urandom_range(3)] = {$urandom, $urandom};
   endtask

   // Whole snapshots for the most part; some cut short, some random beats.
   task automatic run_snapshots(input int beat_budget);
      int sent;
      int roll;
      int top;
      sent = 0;
      while (sent < beat_budget) begin
         roll = $urandom_range(99);
         if (roll < 84) begin
            toggle_some_keys();
            for (int c = 0; c < NUM_CHUNKS; c++)
               send_chunk(2'(c), target[c], c == NUM_CHUNKS - 1);
            sent += NUM_CHUNKS;
         end else if (roll < 90) begin
            toggle_some_keys();
            top = $urandom_range(2);
            for (int c = 0; c <= top; c++) send_chunk(2'(c), target[c], c == top);
            sent += top + 1;
         end else begin
            top = $urandom_range(1, 4);
            for (int i = 0; i < top; i++) begin
               roll = $urandom_range(3);
               send_chunk(2'(roll), $urandom_range(1) ? {$urandom, $urandom} : target[roll],
                          $urandom_range(2) == 0);
            end
            sent += top;
         end
      end
   endtask

   function automatic bit [7:0] pool_code();
      case ($urandom_range(7))
         0: return 8'd0;
         1: return 8'd50;
         2: return 8'd105;
         3: return 8'd64;
         4: return 8'd255;
         5: return 8'd1;
         default: return 8'($urandom_range(1, 255));
      endcase
   endfunction

   // -------------------------------------------------------------------------
   // Main sequence
   // -------------------------------------------------------------------------
   initial begin
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // shift on 50 and 62, caps 66, control 37 and 105, alt 64 and 108,
      // mod four 133; 105 also in the top slot of mod five so the higher
      // group wins
      group_plan[REG_SHIFT_GROUP]     = 64'h0000_0000_0000_3E32;
      group_plan[REG_LOCK_GROUP]      = 64'h0000_0000_0000_0042;
      group_plan[REG_CONTROL_GROUP]   = 64'h0000_0000_6900_0025;
      group_plan[REG_MOD_ONE_GROUP]   = 64'h0000_0000_0000_6C40;
      group_plan[REG_MOD_TWO_GROUP]   = 64'h0;
      group_plan[REG_MOD_THREE_GROUP] = 64'h0;
      group_plan[REG_MOD_FOUR_GROUP]  = 64'h0000_0000_0000_0085;
      group_plan[REG_MOD_FIVE_GROUP]  = 64'h6900_0000_0000_0000;
      write_groups();

      // directed beats
      send_chunk(2'd0, 64'h0, 1'b0);             // unchanged snapshot: no event
      send_chunk(2'd1, 64'h0, 1'b0);
      send_chunk(2'd2, 64'h0, 1'b0);
      send_chunk(2'd3, 64'h0, 1'b1);
      send_chunk(2'd0, 64'h1, 1'b0);             // key zero down, never a modifier
      send_chunk(2'd1, '1, 1'b0);                // event already given: ignored
      send_chunk(2'd3, '1, 1'b1);                // ignored, ends snapshot
      send_chunk(2'd1, '1, 1'b1);                // lone last chunk: key 64, alt on
      send_chunk(2'd3, 64'h8000_0000_0000_0000, 1'b1); // key 255
      send_chunk(2'd0, 64'h1 | (64'h1 << 50), 1'b1);   // shift slot 0 down
      send_chunk(2'd0, 64'h1 | (64'h1 << 50) | (64'h1 << 62), 1'b1);
      send_chunk(2'd0, 64'h1 | (64'h1 << 62), 1'b1);   // shift still held
      send_chunk(2'd0, 64'h1, 1'b1);                   // shift released
      send_chunk(2'd1, 64'h1 | (64'h1 << 41), 1'b1);   // key 105: mod five
      send_chunk(2'd0, 64'h0, 1'b1);                   // key zero up
      send_chunk(2'd2, '1, 1'b1);                      // key 128
      send_chunk(2'd1, 64'h1, 1'b1);                   // key 105 up
      send_chunk(2'd2, '0, 1'b0);                      // key 128 up
      send_chunk(2'd3, '0, 1'b1);                      // ignored
      settle();

      foreach (target[c]) target[c] = tracker.keymap[c];
      run_snapshots(300);
      settle();

      // every slot empty
      foreach (group_plan[g]) group_plan[g] = '0;
      write_groups();
      run_snapshots(300);
      settle();

      // every slot holds 255: the top group and slot take it; no idling here
      foreach (group_plan[g]) group_plan[g] = '1;
      write_groups();
      calm = 1'b1;
      run_snapshots(300);
      settle();
      calm = 1'b0;

      // few distinct codes, many repeats across groups; long result hold-off
      foreach (group_plan[g])
         for (int s = 0; s < 8; s++) group_plan[g][8*s +: 8] = pool_code();
      write_groups();
      run_snapshots(40);
      hold_request = 1'b1;
      run_snapshots(260);
      settle();

      // fully random codes
      foreach (group_plan[g]) group_plan[g] = {$urandom, $urandom};
      write_groups();
      run_snapshots(330);
      settle();

      if (tracker.mismatches == 0)
         $display("Test completed successfully");
      else
         $display("Test completed with failures");
      $finish;
   end

endmodule

FILE: files.f
rtl/core/kced_pkg.sv
rtl/core/key_change_event_detector.sv
rtl/core/kced_checker.sv
tb/testbench.sv
